[design/ulst_pkg.sv]
// ----------------------------------------------------------------------------
// ulst_pkg: shared types for the unsorted key/value table
// Op and status codes, item and result structs, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package ulst_pkg;

	localparam int OP_W    = 3;
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 16;
	localparam int COUNT_W = 5;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT       = 3'd0,
		OP_RETRIEVE     = 3'd1,
		OP_DEL_ONE      = 3'd2,
		OP_DEL_ALL      = 3'd3,
		OP_RESET_CURSOR = 3'd4,
		OP_GET_NEXT     = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_PAST_END  = 2'd3
	} status_t;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [KEY_W-1:0]   item_key;
		logic [VALUE_W-1:0] item_value;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [KEY_W-1:0]   out_key;
		logic [VALUE_W-1:0] out_value;
		logic [COUNT_W-1:0] count;
		logic               is_full;
	} result_t;

	typedef struct packed {
		logic    latch;       // capture the accepted item
		logic    scan_init;   // start a scan at entry zero
		logic    scan_run;    // issue the next scan read and advance
		logic    rescan;      // restart the scan at the entry just refilled
		logic    ins_wr;      // append the item at the end
		logic    next_rd;     // read the entry under the cursor and advance
		logic    cursor_clr;
		logic    swap_rd;     // read the last entry
		logic    swap_wr;     // move the last entry onto the match, shrink count
		logic    finish;      // load the result registers
		logic    fin_data;    // result carries the entry just read
		status_t fin_status;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            full;
		logic            cursor_ok;
		logic            hit;
		logic            miss;
		logic            any;
	} dp_stat_t;

endpackage

[design/ulst_dp.sv]
// ----------------------------------------------------------------------------
// ulst_dp: table datapath
// Entry memory with one write and one registered read port, count and
// cursor registers, the scan pipeline and the result registers.
// ----------------------------------------------------------------------------
module ulst_dp import ulst_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  item_t     item,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	output result_t   result
);

	localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef struct packed {
		logic [KW-1:0]      key;
		logic [VALUE_W-1:0] value;
	} entry_t;

	entry_t mem [CAPACITY];

	logic [OP_W-1:0]    op_q;
	logic [KW-1:0]      key_q;
	logic [VALUE_W-1:0] value_q;
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      cursor_q;
	logic [CW-1:0]      rd_idx_q;
	logic [CW-1:0]      cmp_idx_s1;
	logic               cmp_vld_s1;
	entry_t             rdata_s1;
	logic               any_q;
	status_t            res_status_q;
	logic [KW-1:0]      res_key_q;
	logic [VALUE_W-1:0] res_value_q;

	logic                  scan_go;
	logic [CW-1:0]         last_idx;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	entry_t                wr_data;
	logic [CW+COUNT_W-1:0] cnt_ext;
	logic [KW+KEY_W-1:0]   key_ext;

	assign scan_go  = (rd_idx_q < count_q);
	assign last_idx = count_q - CW'(1);

	always_comb begin
		if (cmd.swap_rd) begin
			rd_addr = last_idx[AW-1:0];
		end else if (cmd.next_rd) begin
			rd_addr = cursor_q[AW-1:0];
		end else begin
			rd_addr = rd_idx_q[AW-1:0];
		end
	end

	assign rd_en   = cmd.swap_rd | cmd.next_rd | (cmd.scan_run & scan_go);
	assign wr_en   = cmd.ins_wr | cmd.swap_wr;
	assign wr_addr = cmd.swap_wr ? cmp_idx_s1[AW-1:0] : count_q[AW-1:0];
	assign wr_data = cmd.swap_wr ? rdata_s1 : entry_t'{key: key_q, value: value_q};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			cursor_q   <= '0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			any_q      <= 1'b0;
		end else begin
			if (cmd.ins_wr) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.swap_wr) begin
				count_q <= last_idx;
			end
			if (cmd.cursor_clr) begin
				cursor_q <= '0;
			end else if (cmd.next_rd) begin
				cursor_q <= cursor_q + CW'(1);
			end
			if (cmd.scan_init) begin
				rd_idx_q   <= '0;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.rescan) begin
				// refilled slot may match again: look at it first
				rd_idx_q   <= cmp_idx_s1;
				cmp_vld_s1 <= 1'b0;
			end else if (cmd.scan_run) begin
				cmp_vld_s1 <= scan_go;
				if (scan_go) begin
					rd_idx_q <= rd_idx_q + CW'(1);
				end
			end
			if (cmd.scan_init) begin
				any_q <= 1'b0;
			end else if (cmd.swap_wr) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= item.op;
			key_q   <= item.item_key[KW-1:0];
			value_q <= item.item_value;
		end
		if (cmd.scan_run && scan_go) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (cmd.finish) begin
			res_status_q <= cmd.fin_status;
			res_key_q    <= cmd.fin_data ? rdata_s1.key : '0;
			res_value_q  <= cmd.fin_data ? rdata_s1.value : '0;
		end
	end

	assign stat.op        = op_q;
	assign stat.full      = (count_q >= CAP_C);
	assign stat.cursor_ok = (cursor_q < count_q);
	assign stat.hit       = cmp_vld_s1 && (rdata_s1.key == key_q);
	assign stat.miss      = !cmp_vld_s1 && !scan_go;
	assign stat.any       = any_q;

	assign cnt_ext = {{COUNT_W{1'b0}}, count_q};
	assign key_ext = {{KEY_W{1'b0}}, res_key_q};

	assign result.status    = res_status_q;
	assign result.out_key   = key_ext[KEY_W-1:0];
	assign result.out_value = res_value_q;
	assign result.count     = cnt_ext[COUNT_W-1:0];
	assign result.is_full   = (count_q == CAP_C);

endmodule

[design/ulst_ctrl.sv]
// ----------------------------------------------------------------------------
// ulst_ctrl: table sequencer
// Decodes the op, runs scans, the swap-with-last removal and the cursor
// read, and raises the result strobe.
// ----------------------------------------------------------------------------
module ulst_ctrl import ulst_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd,
	output logic      busy,
	output logic      done
);

	typedef enum logic [5:0] {
		S_IDLE    = 6'b000001,
		S_DECODE  = 6'b000010,
		S_SCAN    = 6'b000100,
		S_SWAP_RD = 6'b001000,
		S_SWAP_WR = 6'b010000,
		S_NEXT_RD = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   done_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.fin_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.op)
					OP_INSERT: begin
						if (stat.full) begin
							cmd.fin_status = ST_FULL;
						end else begin
							cmd.ins_wr = 1'b1;
						end
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
					OP_RETRIEVE, OP_DEL_ONE, OP_DEL_ALL: begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
					OP_RESET_CURSOR: begin
						cmd.cursor_clr = 1'b1;
						cmd.finish     = 1'b1;
						state_d        = S_IDLE;
					end
					OP_GET_NEXT: begin
						if (stat.cursor_ok) begin
							cmd.next_rd = 1'b1;
							state_d     = S_NEXT_RD;
						end else begin
							cmd.fin_status = ST_PAST_END;
							cmd.finish     = 1'b1;
							state_d        = S_IDLE;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_SCAN: begin
				if (stat.hit) begin
					if (stat.op == OP_RETRIEVE) begin
						cmd.fin_data = 1'b1;
						cmd.finish   = 1'b1;
						state_d      = S_IDLE;
					end else begin
						state_d = S_SWAP_RD;
					end
				end else if (stat.miss) begin
					if (stat.op == OP_DEL_ALL && stat.any) begin
						cmd.fin_status = ST_OK;
					end else begin
						cmd.fin_status = ST_NOT_FOUND;
					end
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.scan_run = 1'b1;
				end
			end
			S_SWAP_RD: begin
				cmd.swap_rd = 1'b1;
				state_d     = S_SWAP_WR;
			end
			S_SWAP_WR: begin
				cmd.swap_wr = 1'b1;
				if (stat.op == OP_DEL_ALL) begin
					cmd.rescan = 1'b1;
					state_d    = S_SCAN;
				end else begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			S_NEXT_RD: begin
				cmd.fin_data = 1'b1;
				cmd.finish   = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= cmd.finish;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

endmodule

[design/unsorted_list_table.sv]
// ----------------------------------------------------------------------------
// unsorted_list_table: bounded unsorted key/value table
// Insert, retrieve, delete-one, delete-all and cursor walk over up to
// CAPACITY entries, one item at a time.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its one result shows
// on result for a single cycle with done high and cannot be held off. The
// entries sit in a memory with one read port, so a search reads one entry a
// cycle; each removal in delete-all adds a swap with the last entry and a
// rescan from the refilled slot, while insert, reset-cursor and get-next
// need no scan.
// A new item may be started in the cycle that done is high.
// ----------------------------------------------------------------------------
module unsorted_list_table import ulst_pkg::*; #(
	parameter int CAPACITY = 16,
	parameter int KEY_BITS = 16
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  item_t   item,
	output logic    busy,
	output logic    done,
	output result_t result
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	ulst_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ulst_dp #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.stat   (stat),
		.result (result)
	);

`ifndef SYNTH
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not raise busy");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status == ST_FULL) |-> result.is_full)
		else $error("table full reported while not full");

	a_no_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != ST_OK) |-> (result.out_key == '0 && result.out_value == '0))
		else $error("failed item carries entry data");
`endif

endmodule
